// ===== sv/upst_pkg.sv =====
package upst_pkg;

	// defaults for the top-level parameters
	localparam int TABLE_ENTRIES_DEF = 128;
	localparam int QUEUE_COUNT_DEF   = 64;

	// cells per group in the first level of the hit encoder
	localparam int GROUP_SIZE = 8;

	localparam int IDENT_W    = 16;
	localparam int CFG_DATA_W = 64;
	localparam int S_TDATA_W  = 96;
	localparam int M_TDATA_W  = 16;

	localparam logic [15:0] IP_HDR_END         = 16'd34;
	localparam logic [15:0] UDP_HDR_END        = 16'd42;
	localparam logic [15:0] ETHERTYPE_IPV4     = 16'h0800;
	localparam logic [7:0]  PROTO_UDP          = 8'd17;
	localparam logic [15:0] FLAG_MF            = 16'h2000;
	localparam logic [15:0] MASK_OFFSET        = 16'h1FFF;
	localparam logic [15:0] FLAG_DF            = 16'h4000;
	localparam logic [15:0] PORT_THRESHOLD_RST = 16'hE000;

	typedef enum logic [1:0] {
		REG_ENABLE,
		REG_PORT_THRESHOLD,
		REG_QUEUE_MASK
	} reg_index_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_INSERT,
		EV_DELETE,
		EV_EVICT
	} table_event_t;

	// shift_in: cells up to pos take the left neighbor, cell 0 takes the key
	// shift_out: cells from pos on take the right neighbor
	typedef enum logic [1:0] {
		OP_HOLD,
		OP_SHIFT_IN,
		OP_SHIFT_OUT
	} cell_op_t;

	typedef struct packed {
		cell_op_t             op;
		logic [IDENT_W-1:0]   key;
	} cell_cmd_t;

endpackage

// ===== sv/upst_cell.sv =====
module upst_cell #(
	parameter int ENTRIES = upst_pkg::TABLE_ENTRIES_DEF,
	parameter int IDX     = 0,
	localparam int IW     = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  upst_pkg::cell_cmd_t          cmd,
	input  logic [IW-1:0]                pos,
	input  logic [upst_pkg::IDENT_W-1:0] left_id,
	input  logic                         left_valid,
	input  logic [upst_pkg::IDENT_W-1:0] right_id,
	input  logic                         right_valid,
	output logic [upst_pkg::IDENT_W-1:0] id,
	output logic                         valid,
	output logic                         match_s1
);
	import upst_pkg::*;

	logic [IDENT_W-1:0] id_q;
	logic               valid_q;
	logic [IW-1:0]      my_idx;
	logic               take_left;
	logic               take_right;

	assign my_idx     = IW'(IDX);
	assign take_left  = (cmd.op == OP_SHIFT_IN) && (my_idx <= pos);
	assign take_right = (cmd.op == OP_SHIFT_OUT) && (my_idx >= pos);

	always_ff @(posedge clk) begin
		if (take_left) begin
			id_q <= left_id;
		end else if (take_right) begin
			id_q <= right_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			match_s1 <= 1'b0;
		end else begin
			if (take_left) begin
				valid_q <= left_valid;
			end else if (take_right) begin
				valid_q <= right_valid;
			end
			match_s1 <= valid_q && (id_q == cmd.key);
		end
	end

	assign id    = id_q;
	assign valid = valid_q;

endmodule

// ===== sv/upst_hit_enc.sv =====
module upst_hit_enc #(
	parameter int ENTRIES = upst_pkg::TABLE_ENTRIES_DEF,
	localparam int IW     = $clog2(ENTRIES)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ENTRIES-1:0] match,
	output logic               hit_any_s3,
	output logic [IW-1:0]      hit_idx_s3
);
	import upst_pkg::*;

	localparam int NG = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

	logic [NG*GROUP_SIZE-1:0]        match_pad;
	logic [NG-1:0][GROUP_SIZE-1:0]   match_grp;
	logic [NG-1:0]                   grp_any_d;
	logic [NG-1:0][IW-1:0]           grp_idx_d;
	logic [NG-1:0]                   grp_any_s2;
	logic [NG-1:0][IW-1:0]           grp_idx_s2;
	logic                            hit_any_d;
	logic [IW-1:0]                   hit_idx_d;

	assign match_pad = (NG*GROUP_SIZE)'(match);
	assign match_grp = match_pad;

	// at most one cell matches, so or-ing the indices encodes it
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_any_d[g] = |match_grp[g];
			grp_idx_d[g] = '0;
			for (int k = 0; k < GROUP_SIZE; k++) begin
				if (match_grp[g][k]) begin
					grp_idx_d[g] = grp_idx_d[g] | IW'(g*GROUP_SIZE + k);
				end
			end
		end
	end

	always_comb begin
		hit_any_d = |grp_any_s2;
		hit_idx_d = '0;
		for (int g = 0; g < NG; g++) begin
			hit_idx_d = hit_idx_d | grp_idx_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_any_s2 <= '0;
			grp_idx_s2 <= '0;
			hit_any_s3 <= 1'b0;
			hit_idx_s3 <= '0;
		end else begin
			grp_any_s2 <= grp_any_d;
			grp_idx_s2 <= grp_idx_d;
			hit_any_s3 <= hit_any_d;
			hit_idx_s3 <= hit_idx_d;
		end
	end

endmodule

// ===== sv/udp_port_steering_with_fragment_table.sv =====
// channel   | group       | transaction contents
// ----------+-------------+--------------------------------------------------
// header in | s_axis_*    | one received packet's header fields
// verdict   | m_axis_*    | steering verdict, target queue, table event
// config    | cfg_*       | register write, no handshake, no read-back
//
// a packet that skips the fragment table goes from idle straight to done; one
// that looks up the table passes the compare, group, encode and apply states,
// set by the compare, the two-level registered hit encoder and the row update
// only one packet is in work at a time; the next is taken once the verdict
// sits in the output register, which holds it while m_axis_tready is low
// reset clears all valid bits of the row at once, no clearing pass

module udp_port_steering_with_fragment_table #(
	parameter int TABLE_ENTRIES = upst_pkg::TABLE_ENTRIES_DEF,
	parameter int QUEUE_COUNT   = upst_pkg::QUEUE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// register write port
	input  logic                            cfg_wen,
	input  upst_pkg::reg_index_t            cfg_index,
	input  logic [upst_pkg::CFG_DATA_W-1:0] cfg_data,
	// header stream
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// frame_length, ether_type, ip_protocol, ip_ident, frag_field,
	// udp_dest_port, rx_queue, zero pad
	input  logic [upst_pkg::S_TDATA_W-1:0]  s_axis_tdata,
	// verdict stream
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// verdict, target_queue, table_event, zero pad
	output logic [upst_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
	import upst_pkg::*;

	localparam int IW = $clog2(TABLE_ENTRIES);
	localparam int QW = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_GRP,
		ST_ENC,
		ST_APPLY,
		ST_DONE
	} state_t;

	state_t state_q;

	// configuration registers
	logic                    enable_q;
	logic [15:0]             thresh_q;
	logic [QUEUE_COUNT-1:0]  mask_q;

	// header fields as they arrive
	logic [15:0] in_flen;
	logic [15:0] in_etype;
	logic [7:0]  in_proto;
	logic [15:0] in_ident;
	logic [15:0] in_frag;
	logic [15:0] in_port;
	logic [5:0]  in_queue;

	logic in_accept;
	logic base_ok;
	logic frag_path;
	logic udp_ok;
	logic bound;

	// per-packet context while the table works
	logic [IDENT_W-1:0] key_q;
	logic               udp_ok_q;
	logic               bound_q;
	logic [5:0]         queue_q;
	logic               mf_q;
	logic               off_nz_q;

	// result waiting for the output register
	logic               res_redirect_q;
	table_event_t       res_event_q;

	// output register
	logic               m_valid_q;
	logic               m_verdict_q;
	logic [5:0]         m_target_q;
	table_event_t       m_event_q;

	// cell row
	cell_cmd_t                   cmd;
	logic [IW-1:0]               cmd_pos;
	logic [IDENT_W-1:0]          chain_id [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0]    chain_valid;
	logic [TABLE_ENTRIES-1:0]    match_vec;
	logic                        hit_any_s3;
	logic [IW-1:0]               hit_idx_s3;
	logic                        table_full;

	logic          apply_redirect;
	table_event_t  apply_event;
	logic          out_free;

	assign in_flen  = s_axis_tdata[15:0];
	assign in_etype = s_axis_tdata[31:16];
	assign in_proto = s_axis_tdata[39:32];
	assign in_ident = s_axis_tdata[55:40];
	assign in_frag  = s_axis_tdata[71:56];
	assign in_port  = s_axis_tdata[87:72];
	assign in_queue = s_axis_tdata[93:88];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	// ipv4 udp with room for the ip header; 34 bytes covers the ethernet check
	assign base_ok = enable_q && (in_flen >= IP_HDR_END) &&
		(in_etype == ETHERTYPE_IPV4) && (in_proto == PROTO_UDP);

	// fragment logic only without don't-fragment and with mf or an offset
	assign frag_path = ((in_frag & FLAG_DF) == '0) &&
		((in_frag & (MASK_OFFSET | FLAG_MF)) != '0);

	assign udp_ok = (in_flen >= UDP_HDR_END) && (in_port >= thresh_q);

	// socket bound on the arrival queue
	assign bound = ({1'b0, in_queue} < 7'(QUEUE_COUNT)) && mask_q[in_queue[QW-1:0]];

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			thresh_q <= PORT_THRESHOLD_RST;
			mask_q   <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_ENABLE:         enable_q <= cfg_data[0];
				REG_PORT_THRESHOLD: thresh_q <= cfg_data[15:0];
				REG_QUEUE_MASK:     mask_q   <= cfg_data[QUEUE_COUNT-1:0];
				default: ;
			endcase
		end
	end

	// row of cells ordered by recency: cell 0 newest, valid cells form a prefix
	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			logic [IDENT_W-1:0] left_id;
			logic               left_valid;
			logic [IDENT_W-1:0] right_id;
			logic               right_valid;

			if (gi == 0) begin : g_head
				assign left_id    = cmd.key;
				assign left_valid = 1'b1;
			end else begin : g_body
				assign left_id    = chain_id[gi-1];
				assign left_valid = chain_valid[gi-1];
			end

			if (gi == TABLE_ENTRIES-1) begin : g_tail
				assign right_id    = '0;
				assign right_valid = 1'b0;
			end else begin : g_inner
				assign right_id    = chain_id[gi+1];
				assign right_valid = chain_valid[gi+1];
			end

			upst_cell #(
				.ENTRIES (TABLE_ENTRIES),
				.IDX     (gi)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.cmd         (cmd),
				.pos         (cmd_pos),
				.left_id     (left_id),
				.left_valid  (left_valid),
				.right_id    (right_id),
				.right_valid (right_valid),
				.id          (chain_id[gi]),
				.valid       (chain_valid[gi]),
				.match_s1    (match_vec[gi])
			);
		end
	endgenerate

	upst_hit_enc #(
		.ENTRIES (TABLE_ENTRIES)
	) u_hit_enc (
		.clk        (clk),
		.arst_n     (arst_n),
		.match      (match_vec),
		.hit_any_s3 (hit_any_s3),
		.hit_idx_s3 (hit_idx_s3)
	);

	// oldest entry sits in the last cell once the row is full
	assign table_full = chain_valid[TABLE_ENTRIES-1];

	// table update, issued in the apply cycle only
	always_comb begin
		cmd.op         = OP_HOLD;
		cmd.key        = key_q;
		cmd_pos        = '0;
		apply_redirect = 1'b0;
		apply_event    = EV_NONE;
		if (state_q == ST_APPLY) begin
			if (hit_any_s3) begin
				// later fragment of a tracked datagram, no port check
				apply_redirect = 1'b1;
				cmd_pos        = hit_idx_s3;
				if (!mf_q) begin
					// last fragment drops the entry
					cmd.op      = OP_SHIFT_OUT;
					apply_event = EV_DELETE;
				end else begin
					// refresh: move to the front
					cmd.op = OP_SHIFT_IN;
				end
			end else if (!off_nz_q && udp_ok_q) begin
				// first fragment on a steered port: push at the front
				apply_redirect = 1'b1;
				cmd.op         = OP_SHIFT_IN;
				cmd_pos        = IW'(TABLE_ENTRIES - 1);
				apply_event    = table_full ? EV_EVICT : EV_INSERT;
			end
		end
	end

	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= '0;
			udp_ok_q       <= 1'b0;
			bound_q        <= 1'b0;
			queue_q        <= '0;
			mf_q           <= 1'b0;
			off_nz_q       <= 1'b0;
			res_redirect_q <= 1'b0;
			res_event_q    <= EV_NONE;
			m_valid_q      <= 1'b0;
			m_verdict_q    <= 1'b0;
			m_target_q     <= '0;
			m_event_q      <= EV_NONE;
		end else begin
			// the done state reloads the output register on its own
			if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						key_q    <= in_ident;
						udp_ok_q <= udp_ok;
						bound_q  <= bound;
						queue_q  <= in_queue;
						mf_q     <= (in_frag & FLAG_MF) != '0;
						off_nz_q <= (in_frag & MASK_OFFSET) != '0;
						if (base_ok && frag_path) begin
							state_q <= ST_CMP;
						end else begin
							res_redirect_q <= base_ok && udp_ok;
							res_event_q    <= EV_NONE;
							state_q        <= ST_DONE;
						end
					end
				end
				ST_CMP:   state_q <= ST_GRP;
				ST_GRP:   state_q <= ST_ENC;
				ST_ENC:   state_q <= ST_APPLY;
				ST_APPLY: begin
					res_redirect_q <= apply_redirect;
					res_event_q    <= apply_event;
					state_q        <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						// no bound socket falls back to host pass, event stands
						m_valid_q   <= 1'b1;
						m_verdict_q <= res_redirect_q && bound_q;
						m_target_q  <= (res_redirect_q && bound_q) ? queue_q : '0;
						m_event_q   <= res_event_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'b0, m_event_q, m_target_q, m_verdict_q};

`ifndef SYNTH
	// valid cells stay a contiguous prefix of the row
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((chain_valid >> 1) & ~chain_valid) == '0)
		else $error("fragment table has a hole");

	// ids in the table are unique, so at most one cell matches
	a_single_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matches the key");

	// an entry is only removed where the lookup found it
	a_delete_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SHIFT_OUT) |-> hit_any_s3)
		else $error("delete without a table hit");

	// a new verdict only comes out of the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("verdict raised outside the done state");
`endif

endmodule
